// ===== hw/rtl/chunk_frame_header_checker_assert.svh =====
// assertion macros shared by the frame header checker modules
`ifndef CHUNK_FRAME_HEADER_CHECKER_ASSERT_SVH
`define CHUNK_FRAME_HEADER_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while in reset
`define CFHC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfhc assertion failed");
// next-cycle implication, sampled on clk, off while in reset
`define CFHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfhc assertion failed");
`else
`define CFHC_ASSERT_IMPL(label, ante, cons)
`define CFHC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/cfhc_pkg.sv =====
// shared types and constants of the frame header checker
package cfhc_pkg;

    localparam int HEADER_BYTES = 32;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam int HDR_BITS     = HEADER_BYTES * 8;
    localparam int COUNT_W      = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // frame mark "EIT1" and flag bits of header byte five
    localparam logic [7:0] MARK_B0    = 8'h45;
    localparam logic [7:0] MARK_B1    = 8'h49;
    localparam logic [7:0] MARK_B2    = 8'h54;
    localparam logic [7:0] MARK_B3    = 8'h31;
    localparam logic [7:0] FLAG_FIRST = 8'h01;
    localparam logic [7:0] FLAG_LAST  = 8'h02;

    localparam int QUEUE_DEPTH = 2;  // power of two
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TDATA_W    = 192;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_FRAME   = 2'd0,
        CFG_MAX_ITEM    = 2'd1,
        CFG_EXP_VERSION = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_LENGTH    = 4'd1,
        ST_MAGIC     = 4'd2,
        ST_VERSION   = 4'd3,
        ST_HEADER    = 4'd4,
        ST_ITEM_LEN  = 4'd5,
        ST_NUMBERING = 4'd6,
        ST_FLAGS     = 4'd7,
        ST_CHUNK_LEN = 4'd8,
        ST_RANGE     = 4'd9
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        logic [15:0] max_frame;
        logic [31:0] max_item;
        logic [7:0]  exp_version;
    } cfg_t;

    // one queue entry: a payload byte, an end of frame, or both
    typedef struct packed {
        logic [7:0]          data;
        logic                eof;
        logic                has_pay;
        logic [COUNT_W-1:0]  count;
        logic [HDR_BITS-1:0] hdr;
    } q_entry_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [31:0] transfer_id;
        logic [31:0] total_item_bytes;
        logic [31:0] item_checksum;
        logic [31:0] chunk_offset;
        logic [15:0] chunk_index;
        logic [15:0] chunk_count;
        logic [15:0] payload_length;
        logic        last_of_run;
    } result_t;

endpackage

// ===== hw/rtl/cfhc_front.sv =====
// front part: byte counter, header capture and queue push
`include "chunk_frame_header_checker_assert.svh"

module cfhc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_data,
    input  logic                in_eof,
    input  logic                q_full,
    output logic                q_push,
    output cfhc_pkg::q_entry_t  q_data
);
    import cfhc_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [7:0]         hdr_reg [HEADER_BYTES];
    logic [HDR_BITS-1:0] hdr_snap;
    logic               accept;
    logic               has_pay;
    logic [COUNT_W-1:0] count_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign has_pay  = count_reg >= COUNT_W'(HEADER_BYTES);

    // saturating byte counter
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = in_eof ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // header capture
    always_ff @(posedge clk)
    begin
        if (accept && !has_pay)
        begin
            hdr_reg[count_reg[HDR_IDX_W-1:0]] <= in_data;
        end
    end

    // header as it stands after this byte
    always_comb
    begin
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            hdr_snap[i*8 +: 8] = (count_reg == COUNT_W'(i)) ? in_data : hdr_reg[i];
        end
    end

    // queue push
    assign q_push          = accept && (has_pay || in_eof);
    assign q_data.data     = in_data;
    assign q_data.eof      = in_eof;
    assign q_data.has_pay  = has_pay;
    assign q_data.count    = count_inc;
    assign q_data.hdr      = hdr_snap;

    `CFHC_ASSERT_NEXT(a_eof_clears_count, accept && in_eof, count_reg == '0)
    `CFHC_ASSERT_IMPL(a_push_not_full, q_push, !q_full)

endmodule

// ===== hw/rtl/cfhc_queue.sv =====
// short queue between front and back parts
`include "chunk_frame_header_checker_assert.svh"

module cfhc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cfhc_pkg::q_entry_t  push_data,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output cfhc_pkg::q_entry_t  head
);
    import cfhc_pkg::*;

    q_entry_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `CFHC_ASSERT_IMPL(a_pop_not_empty, pop, count_reg != '0)
    `CFHC_ASSERT_IMPL(a_fill_in_range, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))

endmodule

// ===== hw/rtl/cfhc_back.sv =====
// back part: header checks, result sequencing and output register
`include "chunk_frame_header_checker_assert.svh"

module cfhc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cfhc_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  cfhc_pkg::q_entry_t  q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output cfhc_pkg::result_t   out_res
);
    import cfhc_pkg::*;

    typedef struct packed {
        logic short_frame;
        logic too_long;
        logic bad_magic;
        logic bad_version;
        logic bad_header;
        logic bad_item;
        logic bad_numbering;
        logic bad_flags;
        logic bad_chunk_len;
        logic bad_range;
    } chk_flags_t;

    function automatic logic [7:0] hbyte(input logic [HDR_BITS-1:0] h, input int at);
        return h[at*8 +: 8];
    endfunction

    function automatic logic [15:0] get16(input logic [HDR_BITS-1:0] h, input int at);
        return {hbyte(h, at + 1), hbyte(h, at)};
    endfunction

    function automatic logic [31:0] get32(input logic [HDR_BITS-1:0] h, input int at);
        return {get16(h, at + 2), get16(h, at)};
    endfunction

    // check stage registers
    logic        s1_valid_reg;
    logic        s1_pend_reg;
    logic [7:0]  s1_data_reg;
    logic        s1_eof_reg;
    chk_flags_t  s1_flags_reg;
    logic [31:0] s1_tid_reg;
    logic [31:0] s1_total_reg;
    logic [31:0] s1_csum_reg;
    logic [31:0] s1_off_reg;
    logic [15:0] s1_idx_reg;
    logic [15:0] s1_cnt_reg;
    logic [15:0] s1_plen_reg;

    logic        out_valid_reg;
    result_t     out_res_reg;

    logic               full;
    logic [COUNT_W-1:0] pay;
    logic [31:0]        f_tid;
    logic [31:0]        f_total;
    logic [31:0]        f_csum;
    logic [31:0]        f_off;
    logic [15:0]        f_idx;
    logic [15:0]        f_cnt;
    logic [15:0]        f_plen;
    logic [15:0]        decl;
    logic [7:0]         exp_flags;
    chk_flags_t         flags;
    logic               out_free;
    logic               emit;
    logic               s1_done;
    logic               s1_load;
    status_t            status;
    result_t            res_next;

    // decode of the queue head
    always_comb
    begin
        full    = q_head.count >= COUNT_W'(HEADER_BYTES);
        pay     = q_head.count - COUNT_W'(HEADER_BYTES);
        f_tid   = full ? get32(q_head.hdr, 8) : '0;
        f_total = full ? get32(q_head.hdr, 12) : '0;
        f_csum  = full ? get32(q_head.hdr, 16) : '0;
        f_off   = full ? get32(q_head.hdr, 20) : '0;
        f_idx   = full ? get16(q_head.hdr, 24) : '0;
        f_cnt   = full ? get16(q_head.hdr, 26) : '0;
        f_plen  = !full ? '0 : (pay[COUNT_W-1] ? 16'hFFFF : pay[15:0]);
        decl    = get16(q_head.hdr, 28);
        exp_flags = ((f_idx == '0) ? FLAG_FIRST : 8'h00)
                  | (({1'b0, f_idx} + 17'd1 == {1'b0, f_cnt}) ? FLAG_LAST : 8'h00);
    end

    // independent checks, prioritised on the way out
    always_comb
    begin
        flags.short_frame   = !full;
        flags.too_long      = q_head.count > {1'b0, cfg.max_frame};
        flags.bad_magic     = (hbyte(q_head.hdr, 0) != MARK_B0)
                           || (hbyte(q_head.hdr, 1) != MARK_B1)
                           || (hbyte(q_head.hdr, 2) != MARK_B2)
                           || (hbyte(q_head.hdr, 3) != MARK_B3);
        flags.bad_version   = hbyte(q_head.hdr, 4) != cfg.exp_version;
        flags.bad_header    = (get16(q_head.hdr, 6) != 16'(HEADER_BYTES))
                           || (get16(q_head.hdr, 30) != '0);
        flags.bad_item      = (f_total == '0) || (f_total > cfg.max_item);
        flags.bad_numbering = (f_cnt == '0) || ({16'b0, f_cnt} > f_total)
                           || (f_idx >= f_cnt);
        flags.bad_flags     = hbyte(q_head.hdr, 5) != exp_flags;
        flags.bad_chunk_len = (decl == '0) || ({1'b0, decl} != pay);
        flags.bad_range     = (f_off >= f_total)
                           || ({{(32-COUNT_W){1'b0}}, pay} > (f_total - f_off));
    end

    // stage handshakes
    assign out_free = !out_valid_reg || out_ready;
    assign emit     = s1_valid_reg && out_free;
    assign s1_done  = emit && !(s1_pend_reg && s1_eof_reg);
    assign s1_load  = q_valid && (!s1_valid_reg || s1_done);
    assign q_pop    = s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_pend_reg  <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
                s1_pend_reg  <= q_head.has_pay;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
                s1_pend_reg  <= 1'b0;
            end
            else if (emit)
            begin
                s1_pend_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_data_reg  <= q_head.data;
            s1_eof_reg   <= q_head.eof;
            s1_flags_reg <= flags;
            s1_tid_reg   <= f_tid;
            s1_total_reg <= f_total;
            s1_csum_reg  <= f_csum;
            s1_off_reg   <= f_off;
            s1_idx_reg   <= f_idx;
            s1_cnt_reg   <= f_cnt;
            s1_plen_reg  <= f_plen;
        end
    end

    // status in order of priority
    always_comb
    begin
        if (s1_flags_reg.short_frame || s1_flags_reg.too_long)
        begin
            status = ST_LENGTH;
        end
        else if (s1_flags_reg.bad_magic)
        begin
            status = ST_MAGIC;
        end
        else if (s1_flags_reg.bad_version)
        begin
            status = ST_VERSION;
        end
        else if (s1_flags_reg.bad_header)
        begin
            status = ST_HEADER;
        end
        else if (s1_flags_reg.bad_item)
        begin
            status = ST_ITEM_LEN;
        end
        else if (s1_flags_reg.bad_numbering)
        begin
            status = ST_NUMBERING;
        end
        else if (s1_flags_reg.bad_flags)
        begin
            status = ST_FLAGS;
        end
        else if (s1_flags_reg.bad_chunk_len)
        begin
            status = ST_CHUNK_LEN;
        end
        else if (s1_flags_reg.bad_range)
        begin
            status = ST_RANGE;
        end
        else
        begin
            status = ST_OK;
        end
    end

    // payload item first, then the summary
    always_comb
    begin
        res_next = '0;
        if (s1_pend_reg)
        begin
            res_next.kind         = KIND_PAYLOAD;
            res_next.payload_byte = s1_data_reg;
            res_next.status       = ST_OK;
            res_next.last_of_run  = !s1_eof_reg;
        end
        else
        begin
            res_next.kind             = KIND_SUMMARY;
            res_next.status           = status;
            res_next.transfer_id      = s1_tid_reg;
            res_next.total_item_bytes = s1_total_reg;
            res_next.item_checksum    = s1_csum_reg;
            res_next.chunk_offset     = s1_off_reg;
            res_next.chunk_index      = s1_idx_reg;
            res_next.chunk_count      = s1_cnt_reg;
            res_next.payload_length   = s1_plen_reg;
            res_next.last_of_run      = 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    `CFHC_ASSERT_IMPL(a_pend_needs_valid, s1_pend_reg, s1_valid_reg)
    `CFHC_ASSERT_IMPL(a_summary_needs_eof, s1_valid_reg && !s1_pend_reg, s1_eof_reg)

endmodule

// ===== hw/rtl/chunk_frame_header_checker.sv =====
// Frame header checker: takes one byte per cycle while its queue is not full, captures
// the 32-byte little-endian header, forwards every later byte as a payload item and ends
// each frame with a summary item carrying the decoded header fields and a status code.
// Each payload byte gives one output item, at one per cycle while the output is ready;
// a frame's final byte gives a summary item, after a payload item if past the header.
// Bytes pass the queue, the check stage and the single output register; a two-entry
// queue separates input from checks, so either side can stall on its own. Configuration
// is written through cfg_wr_en/cfg_index/cfg_wr_data by the user only while idle; the
// block itself does not enforce it.
module chunk_frame_header_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [cfhc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cfhc_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // [7:0] data_byte
    input  logic                                  s_axis_tlast,  // end_of_frame
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [7:0] payload_byte, [11:8] status, [43:12] transfer_id,
    // [75:44] total_item_bytes, [107:76] item_checksum, [139:108] chunk_offset,
    // [155:140] chunk_index, [171:156] chunk_count, [187:172] payload_length, rest zero
    output logic [cfhc_pkg::TDATA_W-1:0]          m_axis_tdata,
    output logic                                  m_axis_tuser,  // kind
    output logic                                  m_axis_tlast   // last_of_run
);
    import cfhc_pkg::*;

    cfg_t     cfg_reg;
    q_entry_t q_in;
    q_entry_t q_head;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_valid;
    result_t  res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_frame   <= 16'd1024;
            cfg_reg.max_item    <= 32'd1048576;
            cfg_reg.exp_version <= 8'd1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MAX_FRAME:   cfg_reg.max_frame   <= cfg_wr_data[15:0];
                CFG_MAX_ITEM:    cfg_reg.max_item    <= cfg_wr_data[31:0];
                CFG_EXP_VERSION: cfg_reg.exp_version <= cfg_wr_data[7:0];
                default:         ;
            endcase
        end
    end

    cfhc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .in_eof   (s_axis_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    cfhc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    cfhc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // output packing
    assign m_axis_tdata = {4'b0, res.payload_length, res.chunk_count, res.chunk_index,
                           res.chunk_offset, res.item_checksum, res.total_item_bytes,
                           res.transfer_id, res.status, res.payload_byte};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last_of_run;

endmodule

// ===== dv/tb_top.sv =====
// testbench for the frame header checker: byte stream in, predicted items compared out
`timescale 1ns / 1ps

module tb_top;
    import cfhc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned TAIL_CYCLES = 8;
    localparam int unsigned MAX_REPORTS = 40;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MAX_FRAME;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    // copy of the block state used for prediction
    logic [7:0]  hdr_cap [0:HEADER_BYTES-1];
    logic [16:0] byte_tally = '0;
    logic [15:0] mdl_max_frame = 16'd1024;
    logic [31:0] mdl_max_item = 32'h0010_0000;
    logic [7:0]  mdl_version = 8'h01;

    result_t     expected_out [$];
    logic [7:0]  frame_buf [$];

    bit          idling_on = 1'b1;
    int unsigned rdy_hold = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    int unsigned items_checked = 0;
    int unsigned frames_seen = 0;
    int unsigned frames_ok = 0;
    int unsigned errors = 0;
    int unsigned reports = 0;

    chunk_frame_header_checker u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly short stalls, now and then a long one
    function automatic int unsigned stall_len();
        if ($urandom_range(99) < 88)
            return $urandom_range(0, 2);
        return $urandom_range(8, 40);
    endfunction

    // output back-pressure
    always @(posedge clk)
    begin
        if (!idling_on)
            m_axis_tready <= 1'b1;
        else if (rdy_hold != 0)
        begin
            m_axis_tready <= 1'b0;
            rdy_hold <= rdy_hold - 1;
        end
        else if ($urandom_range(99) < 70)
            m_axis_tready <= 1'b1;
        else
        begin
            m_axis_tready <= 1'b0;
            rdy_hold <= stall_len();
        end
    end

    // little-endian reads of the captured header
    function automatic logic [15:0] le16(int at);
        return {hdr_cap[at + 1], hdr_cap[at]};
    endfunction

    function automatic logic [31:0] le32(int at);
        return {le16(at + 2), le16(at)};
    endfunction

    // predict the items caused by one accepted input byte
    function automatic void predict_byte(logic [7:0] b, logic eof);
        result_t     r;
        logic [31:0] pay;
        logic [31:0] total;
        logic [31:0] off;
        logic [31:0] idx;
        logic [31:0] cnt;
        logic [7:0]  flags;
        if (byte_tally < HEADER_BYTES)
            hdr_cap[byte_tally[4:0]] = b;
        else
        begin
            r = '0;
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            r.last_of_run = !eof;
            expected_out = {expected_out, r};
        end
        if (byte_tally != COUNT_MAX)
            byte_tally = byte_tally + 1'b1;
        if (!eof)
            return;

        r = '0;
        r.kind = KIND_SUMMARY;
        r.last_of_run = 1'b1;
        r.status = ST_OK;
        pay = '0;
        total = '0;
        off = '0;
        idx = '0;
        cnt = '0;
        // decoded fields only once the whole header is in
        if (byte_tally >= HEADER_BYTES)
        begin
            pay = byte_tally - HEADER_BYTES;
            total = le32(12);
            off = le32(20);
            idx = {16'd0, le16(24)};
            cnt = {16'd0, le16(26)};
            r.transfer_id = le32(8);
            r.total_item_bytes = total;
            r.item_checksum = le32(16);
            r.chunk_offset = off;
            r.chunk_index = idx[15:0];
            r.chunk_count = cnt[15:0];
            r.payload_length = (pay > 32'hFFFF) ? 16'hFFFF : pay[15:0];
        end
        flags = 8'h00;
        if (idx == 0)
            flags = flags | FLAG_FIRST;
        if (idx + 32'd1 == cnt)
            flags = flags | FLAG_LAST;

        // first failing check wins
        if (byte_tally < HEADER_BYTES || byte_tally > mdl_max_frame)
            r.status = ST_LENGTH;
        else if ({hdr_cap[3], hdr_cap[2], hdr_cap[1], hdr_cap[0]}
                 != {MARK_B3, MARK_B2, MARK_B1, MARK_B0})
            r.status = ST_MAGIC;
        else if (hdr_cap[4] != mdl_version)
            r.status = ST_VERSION;
        else if (le16(6) != HEADER_BYTES || le16(30) != 16'd0)
            r.status = ST_HEADER;
        else if (total == 0 || total > mdl_max_item)
            r.status = ST_ITEM_LEN;
        else if (cnt == 0 || cnt > total || idx >= cnt)
            r.status = ST_NUMBERING;
        else if (hdr_cap[5] != flags)
            r.status = ST_FLAGS;
        else if (le16(28) == 16'd0 || {16'd0, le16(28)} != pay)
            r.status = ST_CHUNK_LEN;
        else if (off >= total || pay > total - off)
            r.status = ST_RANGE;
        expected_out = {expected_out, r};
        byte_tally = '0;
    endfunction

    function automatic void check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            if (reports < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want_v, got_v);
            reports++;
        end
    endfunction

    // compare every output item with the oldest prediction
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            items_checked++;
            if (expected_out.size() == 0)
            begin
                errors++;
                if (reports < MAX_REPORTS)
                    $display("%0t: unexpected item, expected none actual %0h kind %0b",
                             $time, m_axis_tdata, m_axis_tuser);
                reports++;
            end
            else
            begin
                want = expected_out.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("payload_byte", 32'(want.payload_byte), 32'(m_axis_tdata[7:0]));
                check_field("status", 32'(want.status), 32'(m_axis_tdata[11:8]));
                check_field("transfer_id", want.transfer_id, m_axis_tdata[43:12]);
                check_field("total_item_bytes", want.total_item_bytes, m_axis_tdata[75:44]);
                check_field("item_checksum", want.item_checksum, m_axis_tdata[107:76]);
                check_field("chunk_offset", want.chunk_offset, m_axis_tdata[139:108]);
                check_field("chunk_index", 32'(want.chunk_index),
                            32'(m_axis_tdata[155:140]));
                check_field("chunk_count", 32'(want.chunk_count),
                            32'(m_axis_tdata[171:156]));
                check_field("payload_length", 32'(want.payload_length),
                            32'(m_axis_tdata[187:172]));
                check_field("tdata padding", 32'd0, 32'(m_axis_tdata[191:188]));
                check_field("last_of_run", 32'(want.last_of_run), 32'(m_axis_tlast));
                if (want.kind == KIND_SUMMARY)
                begin
                    frames_seen++;
                    if (want.status == ST_OK)
                        frames_ok++;
                end
            end
        end
    end

    // send one byte, waiting for the handshake
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int unsigned gap;
        gap = (idling_on && $urandom_range(99) < 25) ? stall_len() + 1 : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= eof;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_byte(b, eof);
        items_sent++;
    endtask

    task automatic send_frame();
        int final_idx;
        final_idx = frame_buf.size() - 1;
        for (int i = 0; i <= final_idx; i++)
            send_byte(frame_buf[i], i == final_idx);
    endtask

    // stop sending and let every pending item drain
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic set_limits(input logic [15:0] frame_lim, input logic [31:0] item_lim,
                              input logic [7:0] ver);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MAX_FRAME;
        cfg_wr_data <= {16'd0, frame_lim};
        @(posedge clk);
        cfg_index <= CFG_MAX_ITEM;
        cfg_wr_data <= item_lim;
        @(posedge clk);
        cfg_index <= CFG_EXP_VERSION;
        cfg_wr_data <= {24'd0, ver};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mdl_max_frame = frame_lim;
        mdl_max_item = item_lim;
        mdl_version = ver;
    endtask

    function automatic void put_le(int pos, int nbytes, logic [31:0] v);
        for (int i = 0; i < nbytes; i++)
            frame_buf[pos + i] = v[8 * i +: 8];
    endfunction

    // well-formed frame with random ids and payload
    function automatic void build_frame(int unsigned pay_len, logic [31:0] total,
                                        logic [31:0] off, logic [15:0] idx, logic [15:0] cnt);
        logic [7:0] flags;
        flags = 8'h00;
        if (idx == 16'd0)
            flags = flags | FLAG_FIRST;
        if ({16'd0, idx} + 32'd1 == {16'd0, cnt})
            flags = flags | FLAG_LAST;
        frame_buf.delete();
        repeat (HEADER_BYTES + pay_len) frame_buf = {frame_buf, 8'($urandom)};
        put_le(0, 1, MARK_B0);
        put_le(1, 1, MARK_B1);
        put_le(2, 1, MARK_B2);
        put_le(3, 1, MARK_B3);
        put_le(4, 1, mdl_version);
        put_le(5, 1, flags);
        put_le(6, 2, HEADER_BYTES);
        put_le(8, 4, $urandom);
        put_le(12, 4, total);
        put_le(16, 4, $urandom);
        put_le(20, 4, off);
        put_le(24, 2, idx);
        put_le(26, 2, cnt);
        put_le(28, 2, pay_len);
        put_le(30, 2, 0);
    endfunction

    // mostly valid chunks, some with one flaw, some short or pure noise
    function automatic void build_random_frame();
        int unsigned pick;
        int unsigned pay_len;
        int unsigned lim;
        int unsigned pos;
        logic [31:0] total;
        logic [31:0] off;
        logic [31:0] hi;
        logic [15:0] cnt;
        logic [15:0] idx;
        pick = $urandom_range(99);
        if (pick >= 88)
        begin
            frame_buf.delete();
            lim = (pick < 95) ? 31 : 80;
            repeat ($urandom_range(1, lim)) frame_buf = {frame_buf, 8'($urandom)};
            return;
        end
        lim = (mdl_max_frame > 56) ? 24 : mdl_max_frame - HEADER_BYTES;
        pay_len = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, lim);
        case ($urandom_range(3))
            0: total = pay_len;
            1: total = pay_len + $urandom_range(0, 200);
            2: total = $urandom;
            default: total = mdl_max_item;
        endcase
        if (total < pay_len)
            total = pay_len;
        if (total == 0)
            total = 1;
        if (total > mdl_max_item && mdl_max_item >= pay_len && mdl_max_item != 0)
            total = $urandom_range((pay_len > 0) ? pay_len : 1, mdl_max_item);
        case ($urandom_range(2))
            0: off = 0;
            1: off = total - pay_len;
            default: off = $urandom_range(0, total - pay_len);
        endcase
        hi = (total > 32'hFFFF) ? 32'hFFFF : total;
        if ($urandom_range(3) == 0)
            cnt = 16'($urandom_range(1, hi));
        else
            cnt = 16'($urandom_range(1, (hi < 5) ? hi : 5));
        idx = 16'($urandom_range(0, cnt - 1));
        build_frame(pay_len, total, off, idx, cnt);
        if (pick >= 70)
        begin
            case ($urandom_range(2))
                0:
                begin
                    pos = $urandom_range(0, HEADER_BYTES - 1);
                    frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
                end
                1: frame_buf = {frame_buf, 8'($urandom)};
                default: void'(frame_buf.pop_back());
            endcase
        end
    endfunction

    // every status code under the reset limits
    task automatic test_header_checks();
        build_frame(1, 1, 0, 0, 1);
        send_frame();
        // one-byte frame and a frame one short of a header
        frame_buf.delete();
        frame_buf = {frame_buf, 8'hA5};
        send_frame();
        build_frame(0, 1, 0, 0, 1);
        void'(frame_buf.pop_back());
        send_frame();
        // header only, declared chunk length zero
        build_frame(0, 10, 0, 0, 1);
        send_frame();
        build_frame(2, 4, 0, 1, 2);
        put_le(3, 1, 8'h32);
        send_frame();
        build_frame(2, 4, 0, 1, 2);
        put_le(4, 1, 8'h02);
        send_frame();
        build_frame(2, 4, 0, 1, 3);
        put_le(6, 2, 33);
        send_frame();
        build_frame(2, 4, 0, 1, 3);
        put_le(30, 2, 16'h0100);
        send_frame();
        build_frame(2, 0, 0, 0, 1);
        send_frame();
        build_frame(2, 32'h0010_0001, 0, 0, 1);
        send_frame();
        // numbering: no chunks, more chunks than bytes, index past the end
        build_frame(2, 8, 0, 0, 1);
        put_le(26, 2, 0);
        send_frame();
        build_frame(2, 2, 0, 0, 3);
        send_frame();
        build_frame(2, 8, 0, 3, 3);
        send_frame();
        build_frame(2, 8, 0, 1, 4);
        put_le(5, 1, 8'h03);
        send_frame();
        build_frame(2, 8, 0, 1, 3);
        send_frame();
        // declared chunk length zero, then off by one
        build_frame(2, 8, 0, 0, 1);
        put_le(28, 2, 0);
        send_frame();
        build_frame(2, 8, 0, 0, 1);
        put_le(28, 2, 3);
        send_frame();
        // offset at the end of the item, chunk running past it
        build_frame(2, 8, 8, 0, 1);
        send_frame();
        build_frame(2, 8, 7, 0, 1);
        send_frame();
        // largest fields that still pass
        build_frame(3, 32'h0010_0000, 32'h000F_FFFD, 16'hFFFE, 16'hFFFF);
        put_le(8, 4, 32'hFFFF_FFFF);
        put_le(16, 4, 32'hFFFF_FFFF);
        send_frame();
    endtask

    // frame limit of 33 and the largest limit, frames at and just over the limit
    task automatic test_frame_limits();
        set_limits(16'd33, 32'h0010_0000, 8'h01);
        build_frame(1, 1, 0, 0, 1);
        send_frame();
        build_frame(2, 2, 0, 0, 1);
        send_frame();
        build_frame(0, 1, 0, 0, 1);
        send_frame();
        // largest limit with a longer chunk
        set_limits(16'hFFFF, 32'h0010_0000, 8'h01);
        build_frame(200, 200, 0, 0, 1);
        send_frame();
    endtask

    task automatic test_item_limits();
        set_limits(16'd1024, 32'd1, 8'h01);
        build_frame(1, 1, 0, 0, 1);
        send_frame();
        build_frame(1, 2, 0, 0, 1);
        send_frame();
        // zero limit rejects every item
        set_limits(16'd1024, 32'd0, 8'h01);
        build_frame(1, 1, 0, 0, 1);
        send_frame();
        set_limits(16'd1024, 32'hFFFF_FFFF, 8'h01);
        build_frame(4, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 0, 16'hFFFF);
        send_frame();
        build_frame(4, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 0, 1);
        send_frame();
    endtask

    task automatic test_version_values();
        set_limits(16'd1024, 32'h0010_0000, 8'h00);
        build_frame(5, 40, 3, 0, 2);
        send_frame();
        set_limits(16'd1024, 32'h0010_0000, 8'hFF);
        build_frame(5, 40, 35, 1, 2);
        send_frame();
        build_frame(5, 40, 0, 0, 1);
        put_le(4, 1, 8'hFE);
        send_frame();
    endtask

    // random frames over several limit settings
    task automatic test_random_traffic();
        int unsigned start_count;
        logic [15:0] frame_lim;
        logic [31:0] item_lim;
        for (int ph = 0; ph < 6; ph++)
        begin
            frame_lim = (ph == 5) ? 16'hFFFF : 16'($urandom_range(40, 1024));
            case ($urandom_range(2))
                0: item_lim = $urandom_range(1, 64);
                1: item_lim = $urandom;
                default: item_lim = 32'h0010_0000;
            endcase
            set_limits(frame_lim, item_lim, 8'($urandom));
            idling_on = (ph != 2);
            start_count = items_sent;
            while (items_sent - start_count < 115)
            begin
                build_random_frame();
                send_frame();
            end
        end
        idling_on = 1'b1;
    endtask

    // reset, tests in turn, drain, verdict
    initial
    begin
        for (int i = 0; i < HEADER_BYTES; i++)
            hdr_cap[i] = 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_header_checks();
        test_frame_limits();
        test_item_limits();
        test_version_values();
        test_random_traffic();
        wait_idle();
        if (expected_out.size() != 0)
            errors++;
        $display("sent %0d input items, checked %0d output items over %0d frames (%0d clean)",
                 items_sent, items_checked, frames_seen, frames_ok);
        $display("covered every status code and frame limits from 33 up to 65535");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cfhc_pkg.sv
hw/rtl/cfhc_front.sv
hw/rtl/cfhc_queue.sv
hw/rtl/cfhc_back.sv
hw/rtl/chunk_frame_header_checker.sv
dv/tb_top.sv
